FILE: src/utf8s_pkg.sv
package utf8s_pkg;

  localparam logic [7:0] QMARK      = 8'h3F;
  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] CODE_CONT  = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] CODE_LEAD2 = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] CODE_LEAD3 = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] CODE_LEAD4 = 8'hF0;

  localparam int unsigned MAX_OUT = 4;
  localparam int unsigned HOLD_DEPTH = 3;

  typedef struct packed {
    logic       bad;
    logic [1:0] extra;
  } lead_t;

  // one request's worth of results, slot 0 first
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [MAX_OUT-1:0]      rep;
    logic [2:0]              cnt;
    logic                    fin;
  } burst_t;

  typedef struct packed {
    logic [1:0] held_count;
    logic [1:0] needed_count;
  } seq_status_t;

  function automatic lead_t lead_decode(input logic [7:0] b);
    lead_t r;
    r.bad   = 1'b0;
    r.extra = 2'd0;
    if ((b & MASK_ASCII) == 8'h00) begin
      r.extra = 2'd0;
    end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
      r.extra = 2'd1;
    end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
      r.extra = 2'd2;
    end else if ((b & MASK_LEAD4) == CODE_LEAD4) begin
      r.extra = 2'd3;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: src/utf8_byte_sanitizer_core.sv
// UTF-8 byte sanitizer. Takes one text byte per request (s_tlast on the last
// byte of a text) and returns the cleaned bytes: complete sequences pass
// unchanged, anything that cannot be part of a valid sequence becomes '?'
// with m_tuser[0] set. A multi-byte sequence is held until it is complete and
// then delivered as a burst; a broken sequence gives one '?' per held byte,
// followed by the judgement of the failing byte. Each input request yields
// 0 to 4 output requests, the last marked by m_tuser[1]; m_tlast marks the
// last output of a text. Throughput is one byte per cycle while each request
// yields at most one result and m_tready is high; a burst of several results
// holds s_tready low until the single output register replaying it sends its
// last one. The first result appears in the cycle after the request is taken.
module utf8_byte_sanitizer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] replaced, [1] run_end
  output logic       m_tlast    // text_end
);
  import utf8s_pkg::*;

  logic        s_accept;
  burst_t      burst;
  seq_status_t status;

  assign s_accept = s_tvalid && s_tready;

  utf8s_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (s_accept),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .burst      (burst),
    .status     (status)
  );

  utf8s_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (s_accept),
    .burst    (burst),
    .ready    (m_tready),
    .free     (s_tready),
    .valid    (m_tvalid),
    .out_byte (m_tdata),
    .replaced (m_tuser[0]),
    .run_end  (m_tuser[1]),
    .text_end (m_tlast)
  );

  // input is taken only when the pending burst drains this cycle
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    s_tready && m_tvalid |-> m_tready && m_tuser[1])
    else $error("request taken while a burst is still pending");

  a_text_end_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("text end not on the last result of a request");

  a_replaced_qmark: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == QMARK)
    else $error("replaced result is not a question mark");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tlast |=> status.held_count == 2'd0 && status.needed_count == 2'd0
      && m_tvalid)
    else $error("final byte left state held or gave no result");

endmodule

FILE: src/utf8s_seq.sv
module utf8s_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  output utf8s_pkg::burst_t     burst,
  output utf8s_pkg::seq_status_t status
);
  import utf8s_pkg::*;

  logic [HOLD_DEPTH-1:0][7:0] held;
  logic [HOLD_DEPTH-1:0][7:0] held_next;
  logic [1:0] held_count;
  logic [1:0] held_count_next;
  logic [1:0] needed_count;
  logic [1:0] needed_count_next;

  lead_t      lead;
  logic       is_cont;
  logic       no_held;
  logic [2:0] prefix;
  logic       from_held;
  logic       tail_v;
  logic [7:0] tail_byte;
  logic       tail_rep;
  logic [MAX_OUT-1:0][7:0] src;

  always_comb begin
    lead      = lead_decode(data_byte);
    is_cont   = (data_byte & MASK_CONT) == CODE_CONT;
    no_held   = (held_count == 2'd0) || (needed_count == 2'd0);
    prefix    = 3'd0;
    from_held = 1'b0;
    tail_v    = 1'b0;
    tail_byte = QMARK;
    tail_rep  = 1'b1;
    held_next = held;
    held_count_next   = 2'd0;
    needed_count_next = 2'd0;

    if (no_held || !is_cont) begin
      // no sequence held, or a broken one: flush any held bytes, then judge this byte as a lead
      prefix = no_held ? 3'd0 : {1'b0, held_count};
      if (lead.bad) begin
        tail_v = 1'b1;
      end else if (lead.extra == 2'd0) begin
        tail_v    = 1'b1;
        tail_byte = data_byte;
        tail_rep  = 1'b0;
      end else if (final_byte) begin
        tail_v = 1'b1;
      end else begin
        held_next[0]      = data_byte;
        held_count_next   = 2'd1;
        needed_count_next = lead.extra;
      end
    end else if (needed_count == 2'd1) begin
      from_held = 1'b1;
      prefix    = {1'b0, held_count};
      tail_v    = 1'b1;
      tail_byte = data_byte;
      tail_rep  = 1'b0;
    end else if (final_byte) begin
      prefix = {1'b0, held_count} + 3'd1;
    end else begin
      if (held_count != 2'd3) begin
        held_next[held_count] = data_byte;
      end
      held_count_next   = held_count + 2'd1;
      needed_count_next = needed_count - 2'd1;
    end

    src = {QMARK, held};
    for (int i = 0; i < MAX_OUT; i++) begin
      if (3'(i) < prefix) begin
        burst.bytes[i] = from_held ? src[i] : QMARK;
        burst.rep[i]   = !from_held;
      end else begin
        burst.bytes[i] = tail_byte;
        burst.rep[i]   = tail_rep;
      end
    end
    burst.cnt = prefix + {2'd0, tail_v};
    burst.fin = final_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count   <= 2'd0;
      needed_count <= 2'd0;
    end else if (accept) begin
      held_count   <= held_count_next;
      needed_count <= needed_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

  assign status.held_count   = held_count;
  assign status.needed_count = needed_count;

endmodule

FILE: src/utf8s_out.sv
module utf8s_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  utf8s_pkg::burst_t burst,
  input  logic              ready,
  output logic              free,
  output logic              valid,
  output logic [7:0]        out_byte,
  output logic              replaced,
  output logic              run_end,
  output logic              text_end
);
  import utf8s_pkg::*;

  logic [MAX_OUT-1:0][7:0] bytes;
  logic [MAX_OUT-1:0]      rep;
  logic [2:0]              cnt;
  logic [1:0]              idx;
  logic                    fin;
  logic                    last;
  logic                    take;

  assign valid    = cnt != 3'd0;
  assign last     = {1'b0, idx} == (cnt - 3'd1);
  assign take     = valid && ready;
  assign free     = !valid || (take && last);
  assign out_byte = bytes[idx];
  assign replaced = rep[idx];
  assign run_end  = last;
  assign text_end = last && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= burst.cnt;
      idx <= 2'd0;
    end else if (take && last) begin
      cnt <= 3'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= burst.bytes;
      rep   <= burst.rep;
      fin   <= burst.fin;
    end
  end

endmodule
